[hdl/m3i_pkg.sv]
// ============================================================================
// m3i_pkg: shared types and constants for the 3x3 matrix inverse
// Holds the request and response payload types, the fixed widths, and the
// index tables that pick the element pairs of every 2x2 cofactor.
// ============================================================================
package m3i_pkg;

    localparam int ELEM_W   = 32;  // Q16.16 element width
    localparam int NUM_EL   = 9;   // elements per matrix
    localparam int COF_W    = 64;  // exact 2x2 cofactor width
    localparam int DET_W    = 98;  // exact determinant width (Q48.48 plus growth)
    localparam int QUO_W    = 32;  // quotient bits produced by the divider
    localparam int IDX_W    = 4;   // index width into the nine elements

    typedef struct packed {
        logic signed [ELEM_W-1:0] a_r0c0;
        logic signed [ELEM_W-1:0] a_r1c0;
        logic signed [ELEM_W-1:0] a_r2c0;
        logic signed [ELEM_W-1:0] a_r0c1;
        logic signed [ELEM_W-1:0] a_r1c1;
        logic signed [ELEM_W-1:0] a_r2c1;
        logic signed [ELEM_W-1:0] a_r0c2;
        logic signed [ELEM_W-1:0] a_r1c2;
        logic signed [ELEM_W-1:0] a_r2c2;
    } t_mat_in;

    typedef struct packed {
        logic signed [ELEM_W-1:0] inv_r0c0;
        logic signed [ELEM_W-1:0] inv_r1c0;
        logic signed [ELEM_W-1:0] inv_r2c0;
        logic signed [ELEM_W-1:0] inv_r0c1;
        logic signed [ELEM_W-1:0] inv_r1c1;
        logic signed [ELEM_W-1:0] inv_r2c1;
        logic signed [ELEM_W-1:0] inv_r0c2;
        logic signed [ELEM_W-1:0] inv_r1c2;
        logic signed [ELEM_W-1:0] inv_r2c2;
        logic                     singular;
        logic                     saturated;
        logic signed [ELEM_W-1:0] det_value;
    } t_mat_out;

    // Cofactor k is A[k]*B[k] - C[k]*D[k], elements in column-major order.
    localparam logic [IDX_W-1:0] COF_PA [0:NUM_EL-1] =
        '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
    localparam logic [IDX_W-1:0] COF_PB [0:NUM_EL-1] =
        '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
    localparam logic [IDX_W-1:0] COF_PC [0:NUM_EL-1] =
        '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
    localparam logic [IDX_W-1:0] COF_PD [0:NUM_EL-1] =
        '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

    // The determinant expands along column 0 with cofactors 0, 3 and 6.
    localparam logic [IDX_W-1:0] DET_COF [0:2] = '{4'd0, 4'd3, 4'd6};

endpackage

[hdl/m3i_stream_if.sv]
// ============================================================================
// m3i_stream_if: valid/ready stream channel
// Carries one payload of a configurable type with a valid/ready handshake.
// ============================================================================
interface m3i_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/matrix3_inverse.sv]
// Every stage, including the 32 divider steps, is pipelined and stalls while the skid is full.
// Throughput: one matrix per cycle while the skid slot is empty.
// The 32 quotient bits come from 32 restoring-divider stages, one bit per stage per lane.
// A two-entry output (register plus skid slot) keeps the input ready while one response waits.
// Reset (synchronous, active low) clears all valid bits; data registers are not reset.
// ============================================================================
// matrix3_inverse: pipelined 3x3 inverse of a signed Q16.16 matrix
// Computes exact cofactors and determinant, then divides each adjugate entry
// by the determinant with nine parallel pipelined dividers, truncating and
// saturating the quotients to Q16.16.
// ============================================================================
module matrix3_inverse (
    input  logic           i_clk,
    input  logic           i_rst_n,
    m3i_stream_if.sink     i_req,
    m3i_stream_if.source   o_rsp
);

    localparam int EW   = m3i_pkg::ELEM_W;
    localparam int NL   = m3i_pkg::NUM_EL;
    localparam int CW   = m3i_pkg::COF_W;
    localparam int DW   = m3i_pkg::DET_W;
    localparam int NDIV = m3i_pkg::QUO_W;
    localparam int NPRE = 7;   // stages ahead of the divider

    // The whole pipeline advances unless the skid slot is occupied.
    logic en;

    // Stage valid bits.
    logic r_vp [0:NPRE-1];
    logic r_dv [0:NDIV];

    // Stage 0: captured request elements.
    logic signed [EW-1:0] r_a [0:NL-1];

    // Stage 1: the eighteen element products; column 0 carried for the determinant.
    logic signed [CW-1:0] r_pab [0:NL-1];
    logic signed [CW-1:0] r_pcd [0:NL-1];
    logic signed [EW-1:0] r_e1  [0:2];

    // Stage 2: cofactors.
    logic signed [CW-1:0] r_cof2 [0:NL-1];
    logic signed [EW-1:0] r_e2   [0:2];

    // Stage 3: cofactor times element, split into upper and lower halves.
    logic signed [CW-1:0] r_phi [0:2];
    logic signed [CW:0]   r_plo [0:2];
    logic signed [CW-1:0] r_cof3 [0:NL-1];

    // Stage 4: recombined determinant terms.
    logic signed [DW-1:0] r_t    [0:2];
    logic signed [CW-1:0] r_cof4 [0:NL-1];

    // Stage 5: determinant.
    logic signed [DW-1:0] r_det;
    logic signed [CW-1:0] r_cof5 [0:NL-1];

    // Stage 6: magnitudes and signs.
    logic [DW-1:0] r_dmag6;
    logic          r_dneg6;
    logic          r_sing6;
    logic [CW-1:0] r_cmag6 [0:NL-1];
    logic          r_cneg6 [0:NL-1];

    // Divider stages; index 0 is the setup stage, index NDIV the last quotient bit.
    logic [DW-1:0]   r_rem  [0:NDIV][0:NL-1];
    logic [NDIV-1:0] r_quo  [0:NDIV][0:NL-1];
    logic            r_ovf  [0:NDIV][0:NL-1];
    logic            r_neg  [0:NDIV][0:NL-1];
    logic [DW-1:0]   r_dmag [0:NDIV];
    logic            r_sing [0:NDIV];
    logic            r_dsat [0:NDIV];
    logic [EW-1:0]   r_dval [0:NDIV];

    // Setup-stage determinant readout.
    logic [DW-33:0]  det_q;
    logic [DW-33:0]  det_lim;
    logic            det_sat;
    logic [EW-1:0]   det_mag;

    // Final saturation and sign, ahead of the output register.
    logic [EW-1:0]       fin_inv [0:NL-1];
    logic                fin_any;
    m3i_pkg::t_mat_out   fin;

    // Output register and skid slot.
    m3i_pkg::t_mat_out r_out;
    m3i_pkg::t_mat_out r_skid;
    logic              r_ov;
    logic              r_skid_v;
    logic              n_ov;
    logic              n_skid_v;
    logic              push;
    logic              pop;
    logic              out_free;

    assign en          = !r_skid_v;
    assign i_req.ready = en;

    // ------------------------------------------------------------------
    // Valid bits travel with the data and move only when the pipe advances.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NPRE; i++) r_vp[i] <= 1'b0;
            for (int j = 0; j <= NDIV; j++) r_dv[j] <= 1'b0;
        end else if (en) begin
            r_vp[0] <= i_req.valid;
            for (int i = 1; i < NPRE; i++) r_vp[i] <= r_vp[i-1];
            r_dv[0] <= r_vp[NPRE-1];
            for (int j = 1; j <= NDIV; j++) r_dv[j] <= r_dv[j-1];
        end
    end

    // ------------------------------------------------------------------
    // Cofactor and determinant datapath.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a[0] <= i_req.data.a_r0c0;
            r_a[1] <= i_req.data.a_r1c0;
            r_a[2] <= i_req.data.a_r2c0;
            r_a[3] <= i_req.data.a_r0c1;
            r_a[4] <= i_req.data.a_r1c1;
            r_a[5] <= i_req.data.a_r2c1;
            r_a[6] <= i_req.data.a_r0c2;
            r_a[7] <= i_req.data.a_r1c2;
            r_a[8] <= i_req.data.a_r2c2;

            for (int k = 0; k < NL; k++) begin
                r_pab[k] <= r_a[m3i_pkg::COF_PA[k]] * r_a[m3i_pkg::COF_PB[k]];
                r_pcd[k] <= r_a[m3i_pkg::COF_PC[k]] * r_a[m3i_pkg::COF_PD[k]];
            end
            for (int j = 0; j < 3; j++) r_e1[j] <= r_a[j];

            for (int k = 0; k < NL; k++) r_cof2[k] <= r_pab[k] - r_pcd[k];
            for (int j = 0; j < 3; j++) r_e2[j] <= r_e1[j];

            // A 64x32 product as two 32x32 partial products.
            for (int j = 0; j < 3; j++) begin
                r_phi[j] <= $signed(r_cof2[m3i_pkg::DET_COF[j]][CW-1:32]) * r_e2[j];
                r_plo[j] <= $signed({1'b0, r_cof2[m3i_pkg::DET_COF[j]][31:0]}) * r_e2[j];
            end
            for (int k = 0; k < NL; k++) r_cof3[k] <= r_cof2[k];

            for (int j = 0; j < 3; j++) begin
                r_t[j] <= (DW'(r_phi[j]) <<< 32) + DW'(r_plo[j]);
            end
            for (int k = 0; k < NL; k++) r_cof4[k] <= r_cof3[k];

            r_det <= r_t[0] + r_t[1] + r_t[2];
            for (int k = 0; k < NL; k++) r_cof5[k] <= r_cof4[k];

            r_dneg6 <= r_det[DW-1];
            r_dmag6 <= r_det[DW-1] ? DW'(-r_det) : DW'(r_det);
            r_sing6 <= (r_det == '0);
            for (int k = 0; k < NL; k++) begin
                r_cneg6[k] <= r_cof5[k][CW-1];
                r_cmag6[k] <= r_cof5[k][CW-1] ? CW'(-r_cof5[k]) : CW'(r_cof5[k]);
            end
        end
    end

    // Determinant readout: drop the 32 extra fraction bits, then clamp.
    always_comb begin
        det_q   = r_dmag6[DW-1:32];
        det_lim = r_dneg6 ? (DW-32)'(33'h1_0000_0000 >> 1) : (DW-32)'(32'h7FFF_FFFF);
        det_sat = det_q > det_lim;
        det_mag = det_sat ? det_lim[EW-1:0] : det_q[EW-1:0];
    end

    // ------------------------------------------------------------------
    // Divider: the quotient is below 2^32 exactly when |cof| < |det|, so the
    // remainder starts as |cof| and each stage yields one quotient bit.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dmag[0] <= r_dmag6;
            r_sing[0] <= r_sing6;
            r_dsat[0] <= det_sat;
            r_dval[0] <= r_dneg6 ? EW'(-det_mag) : det_mag;
            for (int k = 0; k < NL; k++) begin
                r_rem[0][k] <= DW'(r_cmag6[k]);
                r_quo[0][k] <= '0;
                r_ovf[0][k] <= DW'(r_cmag6[k]) >= r_dmag6;
                r_neg[0][k] <= r_cneg6[k] ^ r_dneg6;
            end

            for (int j = 1; j <= NDIV; j++) begin
                r_dmag[j] <= r_dmag[j-1];
                r_sing[j] <= r_sing[j-1];
                r_dsat[j] <= r_dsat[j-1];
                r_dval[j] <= r_dval[j-1];
                for (int k = 0; k < NL; k++) begin
                    logic [DW:0] trial;
                    logic        take;
                    trial = {r_rem[j-1][k], 1'b0};
                    take  = trial >= {1'b0, r_dmag[j-1]};
                    r_rem[j][k] <= take ? DW'(trial - {1'b0, r_dmag[j-1]}) : trial[DW-1:0];
                    r_quo[j][k] <= {r_quo[j-1][k][NDIV-2:0], take};
                    r_ovf[j][k] <= r_ovf[j-1][k];
                    r_neg[j][k] <= r_neg[j-1][k];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Clamp each quotient to the signed range and apply the sign. A singular
    // matrix forces every field to zero except the singular flag.
    // ------------------------------------------------------------------
    always_comb begin
        logic [EW-1:0] lim;
        logic [EW-1:0] mag;
        logic          sat;
        fin_any = r_dsat[NDIV];
        for (int k = 0; k < NL; k++) begin
            lim = r_neg[NDIV][k] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            sat = r_ovf[NDIV][k] || (r_quo[NDIV][k] > lim);
            mag = sat ? lim : r_quo[NDIV][k];
            fin_any = fin_any | sat;
            fin_inv[k] = r_sing[NDIV] ? '0 : (r_neg[NDIV][k] ? EW'(-mag) : mag);
        end
        fin.inv_r0c0  = fin_inv[0];
        fin.inv_r1c0  = fin_inv[1];
        fin.inv_r2c0  = fin_inv[2];
        fin.inv_r0c1  = fin_inv[3];
        fin.inv_r1c1  = fin_inv[4];
        fin.inv_r2c1  = fin_inv[5];
        fin.inv_r0c2  = fin_inv[6];
        fin.inv_r1c2  = fin_inv[7];
        fin.inv_r2c2  = fin_inv[8];
        fin.singular  = r_sing[NDIV];
        fin.saturated = !r_sing[NDIV] && fin_any;
        fin.det_value = r_sing[NDIV] ? '0 : r_dval[NDIV];
    end

    // ------------------------------------------------------------------
    // Output register with a skid slot. A response that arrives while the
    // output is stalled parks in the skid slot; the pipe then holds until
    // the slot drains.
    // ------------------------------------------------------------------
    assign push     = en && r_dv[NDIV];
    assign pop      = r_ov && o_rsp.ready;
    assign out_free = !r_ov || pop;

    always_comb begin
        if (out_free) begin
            n_ov     = r_skid_v || push;
            n_skid_v = 1'b0;
        end else begin
            n_ov     = 1'b1;
            n_skid_v = r_skid_v || push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov     <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_ov     <= n_ov;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_v) begin
                r_out <= r_skid;
            end else if (push) begin
                r_out <= fin;
            end
        end else if (push) begin
            r_skid <= fin;
        end
    end

    assign o_rsp.valid = r_ov;
    assign o_rsp.data  = r_out;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_ov)
        else $error("skid slot holds a response while the output register is empty");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_ov) && !$past(o_rsp.ready))
        else $error("skid slot filled while the output was free");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv[NDIV] && !r_ovf[NDIV][0] |-> r_rem[NDIV][0] < r_dmag[NDIV])
        else $error("divider remainder reached the divisor");

    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.data.singular |->
            o_rsp.data.inv_r0c0 == '0 && o_rsp.data.inv_r1c1 == '0 &&
            o_rsp.data.inv_r2c2 == '0 && !o_rsp.data.saturated &&
            o_rsp.data.det_value == '0)
        else $error("singular response carries nonzero fields");

endmodule

[tb/m3i_inv_checker.sv]
`timescale 1ns / 100ps
// ============================================================================
// m3i_inv_checker: prediction and checking for the 3x3 matrix inverse
// Watches both stream channels, computes the expected inverse of every
// accepted matrix and compares each response field by field, in order.
// ============================================================================
module m3i_inv_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    input  logic               i_req_ready,
    input  m3i_pkg::t_mat_in   i_req_data,
    input  logic               i_rsp_valid,
    input  logic               i_rsp_ready,
    input  m3i_pkg::t_mat_out  i_rsp_data,
    output int                 o_fail_count,
    output int                 o_pending
);

    m3i_pkg::t_mat_out inverse_q[$];

    // Narrow a magnitude with a sign to a saturated 32-bit pattern.
    function automatic logic [31:0] clamp_q16(input logic [127:0] mag, input logic neg,
                                              inout logic sat);
        logic [127:0] lim;
        logic [127:0] v;
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        v = mag;
        if (mag > lim) begin
            sat = 1'b1;
            v = lim;
        end
        return neg ? -v[31:0] : v[31:0];
    endfunction

    function automatic m3i_pkg::t_mat_out invert_matrix(input m3i_pkg::t_mat_in m);
        logic signed [63:0]  e [0:8];
        logic signed [63:0]  cof [0:8];
        logic signed [127:0] det;
        logic [127:0]        dmag;
        logic [127:0]        num;
        logic [31:0]         res [0:8];
        logic                dneg;
        logic                sat;
        logic                qneg;
        m3i_pkg::t_mat_out   r;
        e[0] = m.a_r0c0; e[1] = m.a_r1c0; e[2] = m.a_r2c0;
        e[3] = m.a_r0c1; e[4] = m.a_r1c1; e[5] = m.a_r2c1;
        e[6] = m.a_r0c2; e[7] = m.a_r1c2; e[8] = m.a_r2c2;
        cof[0] = e[4] * e[8] - e[5] * e[7];
        cof[1] = e[2] * e[7] - e[1] * e[8];
        cof[2] = e[1] * e[5] - e[2] * e[4];
        cof[3] = e[5] * e[6] - e[3] * e[8];
        cof[4] = e[0] * e[8] - e[2] * e[6];
        cof[5] = e[2] * e[3] - e[0] * e[5];
        cof[6] = e[3] * e[7] - e[4] * e[6];
        cof[7] = e[1] * e[6] - e[0] * e[7];
        cof[8] = e[0] * e[4] - e[1] * e[3];
        det = 128'(cof[0]) * 128'(e[0]) + 128'(cof[3]) * 128'(e[1])
            + 128'(cof[6]) * 128'(e[2]);
        r = '0;
        if (det == 0) begin
            r.singular = 1'b1;
            return r;
        end
        sat = 1'b0;
        dneg = det[127];
        dmag = dneg ? -det : det;
        for (int k = 0; k < 9; k++) begin
            num = cof[k][63] ? -128'(cof[k]) : 128'(cof[k]);
            num = num << 32;
            qneg = cof[k][63] ^ dneg;
            res[k] = clamp_q16(num / dmag, qneg, sat);
        end
        r.inv_r0c0 = res[0]; r.inv_r1c0 = res[1]; r.inv_r2c0 = res[2];
        r.inv_r0c1 = res[3]; r.inv_r1c1 = res[4]; r.inv_r2c1 = res[5];
        r.inv_r0c2 = res[6]; r.inv_r1c2 = res[7]; r.inv_r2c2 = res[8];
        r.det_value = clamp_q16(dmag >> 32, dneg, sat);
        r.saturated = sat;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        o_fail_count++;
    endtask

    initial o_fail_count = 0;
    assign o_pending = inverse_q.size();

    always @(posedge i_clk) begin
        m3i_pkg::t_mat_out want;
        if (i_rst_n && i_req_valid && i_req_ready)
            inverse_q.push_back(invert_matrix(i_req_data));
        if (i_rst_n && i_rsp_valid && i_rsp_ready) begin
            if (inverse_q.size() == 0) begin
                report_mismatch("unexpected response", 0, 0);
            end else begin
                want = inverse_q.pop_front();
                if (i_rsp_data.inv_r0c0 !== want.inv_r0c0)
                    report_mismatch("inv_r0c0", i_rsp_data.inv_r0c0, want.inv_r0c0);
                if (i_rsp_data.inv_r1c0 !== want.inv_r1c0)
                    report_mismatch("inv_r1c0", i_rsp_data.inv_r1c0, want.inv_r1c0);
                if (i_rsp_data.inv_r2c0 !== want.inv_r2c0)
                    report_mismatch("inv_r2c0", i_rsp_data.inv_r2c0, want.inv_r2c0);
                if (i_rsp_data.inv_r0c1 !== want.inv_r0c1)
                    report_mismatch("inv_r0c1", i_rsp_data.inv_r0c1, want.inv_r0c1);
                if (i_rsp_data.inv_r1c1 !== want.inv_r1c1)
                    report_mismatch("inv_r1c1", i_rsp_data.inv_r1c1, want.inv_r1c1);
                if (i_rsp_data.inv_r2c1 !== want.inv_r2c1)
                    report_mismatch("inv_r2c1", i_rsp_data.inv_r2c1, want.inv_r2c1);
                if (i_rsp_data.inv_r0c2 !== want.inv_r0c2)
                    report_mismatch("inv_r0c2", i_rsp_data.inv_r0c2, want.inv_r0c2);
                if (i_rsp_data.inv_r1c2 !== want.inv_r1c2)
                    report_mismatch("inv_r1c2", i_rsp_data.inv_r1c2, want.inv_r1c2);
                if (i_rsp_data.inv_r2c2 !== want.inv_r2c2)
                    report_mismatch("inv_r2c2", i_rsp_data.inv_r2c2, want.inv_r2c2);
                if (i_rsp_data.singular !== want.singular)
                    report_mismatch("singular", i_rsp_data.singular, want.singular);
                if (i_rsp_data.saturated !== want.saturated)
                    report_mismatch("saturated", i_rsp_data.saturated, want.saturated);
                if (i_rsp_data.det_value !== want.det_value)
                    report_mismatch("det_value", i_rsp_data.det_value, want.det_value);
            end
        end
    end

endmodule

[tb/matrix3_inverse_tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// matrix3_inverse_tb: testbench for the pipelined 3x3 matrix inverse
// Drives directed and random matrices with random gaps and back pressure,
// and lets a separate checker predict and compare every response.
// ============================================================================
module matrix3_inverse_tb;

    localparam int RANDOM_COUNT = 1830;
    localparam int LATENCY      = 40;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;
    bit   stim_done = 1'b0;
    bit   quiet_mode = 1'b0;     // no idling on either side
    bit   hold_off = 1'b0;       // long receiver stall to fill the pipeline

    m3i_stream_if #(.t_payload(m3i_pkg::t_mat_in))  req_if ();
    m3i_stream_if #(.t_payload(m3i_pkg::t_mat_out)) rsp_if ();

    matrix3_inverse DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    m3i_inv_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (req_if.valid),
        .i_req_ready  (req_if.ready),
        .i_req_data   (req_if.data),
        .i_rsp_valid  (rsp_if.valid),
        .i_rsp_ready  (rsp_if.ready),
        .i_rsp_data   (rsp_if.data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        req_if.valid = 1'b0;
        req_if.data  = '0;
        rsp_if.ready = 1'b0;
    end

    // Draw one element. Mostly small values keep the inverse in range so the
    // quotients are exercised; the rest covers the extremes and all bits.
    function automatic logic [31:0] pick_element();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
            2: return 32'($signed($urandom_range(0, 8)) - 4) << 16;
            3: return 32'($signed($urandom_range(0, 64)) - 32);
            default: return 32'($signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000);
        endcase
    endfunction

    function automatic m3i_pkg::t_mat_in random_matrix();
        m3i_pkg::t_mat_in m;
        m.a_r0c0 = pick_element(); m.a_r1c0 = pick_element(); m.a_r2c0 = pick_element();
        m.a_r0c1 = pick_element(); m.a_r1c1 = pick_element(); m.a_r2c1 = pick_element();
        m.a_r0c2 = pick_element(); m.a_r1c2 = pick_element(); m.a_r2c2 = pick_element();
        // Some matrices get a repeated column so the determinant is exactly zero.
        if ($urandom_range(0, 15) == 0) begin
            m.a_r0c2 = m.a_r0c0; m.a_r1c2 = m.a_r1c0; m.a_r2c2 = m.a_r2c0;
        end
        return m;
    endfunction

    // Offer one request and hold it until the block takes it. Valid drops
    // only while idling, so back-to-back requests keep it high.
    task automatic send_matrix(input m3i_pkg::t_mat_in m);
        while (!quiet_mode && $urandom_range(0, 99) < 30) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= m;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
    endtask

    function automatic m3i_pkg::t_mat_in diag_matrix(input logic [31:0] a,
                                                     input logic [31:0] b,
                                                     input logic [31:0] c);
        m3i_pkg::t_mat_in m;
        m = '0;
        m.a_r0c0 = a; m.a_r1c1 = b; m.a_r2c2 = c;
        return m;
    endfunction

    // Receiver: random stalls, a quiet stretch, and one long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n)
            rsp_if.ready <= 1'b0;
        else
            rsp_if.ready <= !hold_off && (quiet_mode || $urandom_range(0, 99) >= 30);
    end

    initial begin
        m3i_pkg::t_mat_in m;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: identity, scaled diagonals, an all-zero matrix, a repeated
        // row, extreme elements, and a tiny determinant that overflows the quotients.
        send_matrix(diag_matrix(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
        send_matrix(diag_matrix(32'h0002_0000, 32'hFFFC_0000, 32'h0000_8000));
        send_matrix(diag_matrix(32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
        send_matrix(diag_matrix(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_matrix(diag_matrix(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_matrix(diag_matrix(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
        send_matrix('0);
        send_matrix({9{32'hFFFF_FFFF}});
        send_matrix({9{32'h8000_0000}});
        send_matrix({9{32'h7FFF_FFFF}});
        m = diag_matrix(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        m.a_r0c1 = 32'h0001_0000;
        m.a_r1c0 = 32'h0001_0000;     // two equal rows: singular
        send_matrix(m);
        m = diag_matrix(32'h0001_0000, 32'h0001_0000, 32'h0000_0001);
        send_matrix(m);
        m = diag_matrix(32'h0100_0000, 32'hFF00_0000, 32'h0100_0000);
        send_matrix(m);               // determinant saturates
        for (int k = 0; k < 6; k++)
            send_matrix(random_matrix());

        // Random traffic; a quiet stretch and a long hold-off in the middle.
        for (int n = 0; n < RANDOM_COUNT; n++) begin
            if (n == 400)
                quiet_mode = 1'b1;
            if (n == 600)
                quiet_mode = 1'b0;
            if (n == 900)
                hold_off = 1'b1;
            send_matrix(random_matrix());
        end
        req_if.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Hold-off counted in its own process; the sender keeps offering meanwhile.
    initial begin
        wait (hold_off);
        repeat (200) @(posedge i_clk);
        hold_off = 1'b0;
    end

    initial begin
        wait (stim_done);
        while (pending != 0)
            @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (fail_count == 0)
            $display("matrix3_inverse test passed");
        else
            $display("matrix3_inverse test failed");
        $finish;
    end

    initial begin
        #(12 * 200000);
        $display("matrix3_inverse test failed");
        $finish;
    end

endmodule
